FILE: rtl/core/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// types and constants shared by the packed row unpacker modules
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned ADDR_W = 1;
  localparam int unsigned USER_W = 1;
  localparam int unsigned BIT_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [ADDR_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [ADDR_W-1:0] REG_ROW_COUNT = 1'b1;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 9'd8;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 9'd8;

  // last bit position of a byte
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } pru_state_t;

  // one output byte with its row and frame marks
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last_row;
    logic              last_frame;
  } pru_beat_t;

endpackage

FILE: rtl/core/pru_bit_unit.sv
// ----------------------------------------------------------------------------
// pru_bit_unit
// shared bit step: moves one pixel from the input byte into the output byte
// ----------------------------------------------------------------------------
module pru_bit_unit (
  input  logic [pru_pkg::BYTE_W-1:0]    sh_byte,
  input  logic [pru_pkg::BYTE_W-1:0]    accum,
  input  logic [pru_pkg::BIT_IDX_W-1:0] fill,
  input  logic                          row_end,
  output logic [pru_pkg::BYTE_W-1:0]    sh_byte_nxt,
  output logic [pru_pkg::BYTE_W-1:0]    accum_nxt,
  output logic [pru_pkg::BIT_IDX_W-1:0] fill_nxt,
  output logic                          emit,
  output logic [pru_pkg::BYTE_W-1:0]    byte_out
);
  import pru_pkg::*;

  logic                    pix;
  logic [BIT_IDX_W-1:0]    pos;
  logic [BYTE_W-1:0]       merged;

  always_comb begin
    pix         = sh_byte[BYTE_W-1];
    sh_byte_nxt = {sh_byte[BYTE_W-2:0], 1'b0};
    // msb first: pixel lands at position 7 - fill
    pos         = LAST_BIT - fill;
    merged      = accum | (BYTE_W'(pix) << pos);
    byte_out    = merged;
    emit        = row_end || (fill == LAST_BIT);
    if (emit) begin
      accum_nxt = '0;
      fill_nxt  = '0;
    end else begin
      accum_nxt = merged;
      fill_nxt  = fill + BIT_IDX_W'(1);
    end
  end

endmodule

FILE: rtl/core/pru_out_stage.sv
// ----------------------------------------------------------------------------
// pru_out_stage
// output register holding one result request until the sink takes it
// ----------------------------------------------------------------------------
module pru_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  pru_pkg::pru_beat_t         beat,
  output logic                       slot_free,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pru_pkg::BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic                       out_tlast,
  output logic [pru_pkg::USER_W-1:0] out_tuser   // [0] last_in_frame
);
  import pru_pkg::*;

  logic      valid_r, valid_nxt;
  pru_beat_t beat_r;

  assign slot_free = !valid_r || out_tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = beat_r.data;
  assign out_tlast  = beat_r.last_row;
  assign out_tuser  = USER_W'(beat_r.last_frame);

endmodule

FILE: rtl/core/packed_row_unpacker_core.sv
// ----------------------------------------------------------------------------
// packed_row_unpacker_core
// turns a bit-packed monochrome frame into byte-aligned rows
// ----------------------------------------------------------------------------
// Each input byte is taken apart one pixel per clock, msb first, by a single
// bit step unit under a small sequencer: the idle state takes the request,
// then the run state steps through the bits of the byte and stops after its
// last bit or when the frame ends inside it. A result byte leaves when a row
// ends or eight pixels have gathered; out_tlast marks a row end and
// out_tuser[0] the end of the frame. A waiting result holds the bit steps
// back. Rows start on a fresh byte and unused low bits of a row's last byte
// read as zero. Register writes take effect at once; row_width and row_count
// are clamped to 1..MAX_ROW_WIDTH and 1..MAX_ROWS.
// ----------------------------------------------------------------------------
module packed_row_unpacker_core #(
  parameter int unsigned MAX_ROW_WIDTH = 256,
  parameter int unsigned MAX_ROWS      = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [pru_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [pru_pkg::CFG_W-1:0]   cfg_wdata,
  // packed input
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pru_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] packed_byte
  // aligned output
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pru_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,  // last_in_row
  output logic [pru_pkg::USER_W-1:0]  out_tuser   // [0] last_in_frame
);
  import pru_pkg::*;

  // pixel counter holds 0..MAX_ROW_WIDTH-1, compare width covers the register
  localparam int unsigned CW  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned EW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RCW = (RIW + 1 > CFG_W) ? RIW + 1 : CFG_W;

  pru_state_t           state_r, state_nxt;
  logic [BYTE_W-1:0]    sh_r, sh_nxt;
  logic [BIT_IDX_W-1:0] k_r, k_nxt;
  logic [BYTE_W-1:0]    accum_r, accum_nxt;
  logic [BIT_IDX_W-1:0] fill_r, fill_nxt;
  logic [CW-1:0]        bir_r, bir_nxt;
  logic [RIW-1:0]       row_r, row_nxt;
  logic [CFG_W-1:0]     row_width_r, row_count_r;

  logic [EW-1:0]        rw_ext, eff_w, bit_inc;
  logic [RCW-1:0]       rc_ext, eff_c, row_inc;
  logic                 row_end, frame_end, step, slot_free;

  logic [BYTE_W-1:0]    u_sh_nxt, u_accum_nxt, u_byte;
  logic [BIT_IDX_W-1:0] u_fill_nxt;
  logic                 u_emit;
  pru_beat_t            beat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_WIDTH: row_width_r <= cfg_wdata;
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped width and count
  always_comb begin
    rw_ext = EW'(row_width_r);
    if (rw_ext == '0) begin
      eff_w = EW'(1);
    end else if (rw_ext > EW'(MAX_ROW_WIDTH)) begin
      eff_w = EW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    rc_ext = RCW'(row_count_r);
    if (rc_ext == '0) begin
      eff_c = RCW'(1);
    end else if (rc_ext > RCW'(MAX_ROWS)) begin
      eff_c = RCW'(MAX_ROWS);
    end else begin
      eff_c = rc_ext;
    end
  end

  // row and frame end for the pixel now in the unit
  assign bit_inc   = EW'(bir_r) + EW'(1);
  assign row_inc   = RCW'(row_r) + RCW'(1);
  assign row_end   = (bit_inc >= eff_w);
  assign frame_end = row_end && (row_inc >= eff_c);

  // a bit step only runs when the output register can take its result
  assign step      = (state_r == ST_RUN) && slot_free;
  assign in_tready = (state_r == ST_IDLE);

  pru_bit_unit u_bit (
    .sh_byte     (sh_r),
    .accum       (accum_r),
    .fill        (fill_r),
    .row_end     (row_end),
    .sh_byte_nxt (u_sh_nxt),
    .accum_nxt   (u_accum_nxt),
    .fill_nxt    (u_fill_nxt),
    .emit        (u_emit),
    .byte_out    (u_byte)
  );

  assign beat.data       = u_byte;
  assign beat.last_row   = row_end;
  assign beat.last_frame = frame_end;

  pru_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && u_emit),
    .beat       (beat),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    k_nxt     = k_r;
    accum_nxt = accum_r;
    fill_nxt  = fill_r;
    bir_nxt   = bir_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sh_nxt    = in_tdata;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step) begin
          sh_nxt    = u_sh_nxt;
          accum_nxt = u_accum_nxt;
          fill_nxt  = u_fill_nxt;
          k_nxt     = k_r + BIT_IDX_W'(1);
          if (row_end) begin
            bir_nxt = '0;
            row_nxt = frame_end ? '0 : row_inc[RIW-1:0];
          end else begin
            bir_nxt = bit_inc[CW-1:0];
          end
          // rest of the byte is dropped once the frame is complete
          if (frame_end || (k_r == LAST_BIT)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      accum_r <= '0;
      fill_r  <= '0;
      bir_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      accum_r <= accum_nxt;
      fill_r  <= fill_nxt;
      bir_r   <= bir_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

`ifndef ASSERT_OFF
  // a taken request keeps the input closed for the bit cycles
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready straight after a request was taken");

  // a stalled output freezes the bit position
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && out_tvalid && !out_tready) |=> $stable(k_r))
    else $error("bit step ran while the output was blocked");

  // frame end only ever comes with a row end
  a_frame_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without row end");

  // counters stay inside their clamped ranges
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    RCW'(row_r) < RCW'(MAX_ROWS))
    else $error("row index out of range");

  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(bir_r) < EW'(MAX_ROW_WIDTH))
    else $error("pixel counter out of range");
`endif

endmodule
